FILE: sv/rrts_pkg.sv
`default_nettype none

package rrts_pkg;

    // widths of the request and result fields
    localparam int KIND_W    = 2;
    localparam int TARGET_W  = 6;
    localparam int STATUS_W  = 2;
    localparam int SLOT_FW   = 6;
    localparam int SLOT_ST_W = 2;

    // request kinds
    localparam logic [KIND_W-1:0] K_CREATE = 2'd0;
    localparam logic [KIND_W-1:0] K_YIELD  = 2'd1;
    localparam logic [KIND_W-1:0] K_EXIT   = 2'd2;
    localparam logic [KIND_W-1:0] K_JOIN   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] S_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] S_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] S_BAD_TGT  = 2'd2;
    localparam logic [STATUS_W-1:0] S_WAITING  = 2'd3;

    // slot states
    localparam logic [SLOT_ST_W-1:0] SL_FREE     = 2'd0;
    localparam logic [SLOT_ST_W-1:0] SL_RUNNABLE = 2'd1;
    localparam logic [SLOT_ST_W-1:0] SL_RUNNING  = 2'd2;
    localparam logic [SLOT_ST_W-1:0] SL_FINISHED = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming request
        logic commit;   // update the slot table and load the result register
    } rrts_cmd_t;

endpackage

`default_nettype wire

FILE: sv/rrts_ctrl.sv
`default_nettype none

module rrts_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output rrts_pkg::rrts_cmd_t   cmd
);
    import rrts_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic in_acc;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    // result register can take a new result this cycle
    assign out_free = !m_valid_reg || m_tready;

    assign cmd.capture = in_acc;
    assign cmd.commit  = (state_reg == ST_EXEC) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    a_acc_busy : assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("request taken but input still ready");

    a_commit_ready : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> s_tready)
        else $error("no return to idle after commit");

    a_commit_valid : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("committed result not presented");

    a_commit_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_valid_reg || m_tready))
        else $error("result overwritten before taken");

endmodule

`default_nettype wire

FILE: sv/rrts_dp.sv
`default_nettype none

module rrts_dp
#(
    parameter int NUM_SLOTS = 16
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rrts_pkg::rrts_cmd_t               cmd,
    input  wire logic [rrts_pkg::KIND_W-1:0]       kind,
    input  wire logic [rrts_pkg::TARGET_W-1:0]     target,
    output logic      [rrts_pkg::STATUS_W-1:0]     status,
    output logic      [rrts_pkg::SLOT_FW-1:0]      new_slot,
    output logic      [rrts_pkg::SLOT_FW-1:0]      running_slot
);
    import rrts_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;

    // lowest set bit of a vector as a one-hot
    function automatic logic [NUM_SLOTS-1:0] lowest(input logic [NUM_SLOTS-1:0] v);
        return v & (~v + NUM_SLOTS'(1));
    endfunction

    function automatic logic [SLOT_W-1:0] oh_enc(input logic [NUM_SLOTS-1:0] oh);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (oh[i])
            begin
                idx = idx | SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    logic [KIND_W-1:0]    kind_reg;
    logic [TARGET_W-1:0]  target_reg;
    logic [SLOT_ST_W-1:0] slot_state_reg [NUM_SLOTS];
    logic [SLOT_ST_W-1:0] slot_state_next [NUM_SLOTS];
    logic [SLOT_W-1:0]    cur_reg;
    logic [SLOT_W-1:0]    cur_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [SLOT_FW-1:0]   new_slot_reg;
    logic [SLOT_FW-1:0]   new_slot_next;
    logic [SLOT_FW-1:0]   running_reg;

    logic [SLOT_ST_W-1:0] base_st [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] cur_oh;
    logic [NUM_SLOTS-1:0] above;
    logic [NUM_SLOTS-1:0] free_vec;
    logic [NUM_SLOTS-1:0] run_vec;
    logic [NUM_SLOTS-1:0] run_hi;
    logic [NUM_SLOTS-1:0] free_oh;
    logic [NUM_SLOTS-1:0] yld_oh;
    logic [NUM_SLOTS-1:0] tgt_oh;
    logic [SLOT_W-1:0]    tgt_idx;
    logic                 tgt_ok;
    logic                 tgt_fin;
    logic                 free_found;
    logic                 yld_found;
    logic                 do_yield;
    logic                 do_create;
    logic                 do_free;

    assign tgt_idx = target_reg[SLOT_W-1:0];
    assign tgt_ok  = (target_reg != '0) &&
                     ({1'b0, target_reg} < (TARGET_W+1)'(NUM_SLOTS));
    assign tgt_fin = (slot_state_reg[tgt_idx] == SL_FINISHED);

    assign do_create = (kind_reg == K_CREATE);
    assign do_free   = (kind_reg == K_JOIN) && tgt_ok && tgt_fin;
    assign do_yield  = (kind_reg == K_YIELD) || (kind_reg == K_EXIT) ||
                       ((kind_reg == K_JOIN) && tgt_ok && !tgt_fin);

    // per-slot views of the table
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            cur_oh[i] = (SLOT_W'(i) == cur_reg);
            above[i]  = (SLOT_W'(i) > cur_reg);
            tgt_oh[i] = (SLOT_W'(i) == tgt_idx);
            // exit marks the current slot finished before the yield
            if ((kind_reg == K_EXIT) && cur_oh[i])
            begin
                base_st[i] = SL_FINISHED;
            end
            else
            begin
                base_st[i] = slot_state_reg[i];
            end
            // the running slot counts as runnable during the search
            run_vec[i]  = (base_st[i] == SL_RUNNABLE) || (base_st[i] == SL_RUNNING);
            free_vec[i] = (i != 0) && (slot_state_reg[i] == SL_FREE);
        end
    end

    // round-robin pick: slots above the current one first, then wrap
    assign run_hi     = run_vec & above;
    assign yld_oh     = lowest((run_hi != '0) ? run_hi : run_vec);
    assign yld_found  = (run_vec != '0);
    assign free_oh    = lowest(free_vec);
    assign free_found = (free_vec != '0);

    always_comb
    begin
        cur_next      = cur_reg;
        status_next   = S_OK;
        new_slot_next = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_state_next[i] = slot_state_reg[i];
            if (do_create)
            begin
                if (free_oh[i])
                begin
                    slot_state_next[i] = SL_RUNNABLE;
                end
            end
            else if (do_free)
            begin
                if (tgt_oh[i])
                begin
                    slot_state_next[i] = SL_FREE;
                end
            end
            else if (do_yield)
            begin
                if (!yld_found)
                begin
                    slot_state_next[i] = base_st[i];
                end
                else if (yld_oh[i])
                begin
                    slot_state_next[i] = SL_RUNNING;
                end
                else if (base_st[i] == SL_RUNNING)
                begin
                    slot_state_next[i] = SL_RUNNABLE;
                end
                else
                begin
                    slot_state_next[i] = base_st[i];
                end
            end
        end

        if (do_create)
        begin
            if (free_found)
            begin
                new_slot_next = SLOT_FW'(oh_enc(free_oh));
            end
            else
            begin
                status_next = S_FULL;
            end
        end
        else if ((kind_reg == K_JOIN) && !tgt_ok)
        begin
            status_next = S_BAD_TGT;
        end
        else if ((kind_reg == K_JOIN) && !tgt_fin)
        begin
            status_next = S_WAITING;
        end

        if (do_yield && yld_found)
        begin
            cur_next = oh_enc(yld_oh);
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= kind;
            target_reg <= target;
        end
        if (cmd.commit)
        begin
            status_reg   <= status_next;
            new_slot_reg <= new_slot_next;
            running_reg  <= SLOT_FW'(cur_next);
        end
    end

    // slot table and current slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_state_reg[i] <= (i == 0) ? SL_RUNNING : SL_FREE;
            end
            cur_reg <= '0;
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_state_reg[i] <= slot_state_next[i];
            end
            cur_reg <= cur_next;
        end
    end

    assign status       = status_reg;
    assign new_slot     = new_slot_reg;
    assign running_slot = running_reg;

endmodule

`default_nettype wire

FILE: sv/round_robin_thread_slot_scheduler.sv
`default_nettype none

// round-robin thread slot scheduler: holds a table of NUM_SLOTS slots (free,
// runnable, running, finished) and the current slot; after reset slot 0 is
// running and the rest are free. a request carries a kind on s_tuser (create,
// yield, exit, join) and a join target on s_tdata; each request yields exactly
// one result on the master side with a status, the slot claimed by a create
// and the slot running afterwards. a request is latched when it is taken; its
// update cycle then searches and updates the whole table and loads the result
// register. the next request is taken in the cycle after that update,
// while the previous result may still wait in the output register; a request
// only stalls in its update cycle when that register still holds an untaken
// result. a new request is not taken until the previous one has had its
// single table update.
module round_robin_thread_slot_scheduler
#(
    parameter int NUM_SLOTS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [5:0] target, [7:6] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // [1:0] status, [7:2] new_slot,
                                        // [13:8] running_slot, [15:14] zero
);
    import rrts_pkg::*;

    rrts_cmd_t             cmd;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_FW-1:0]    new_slot;
    logic [SLOT_FW-1:0]    running_slot;

    // handshake and sequencing
    rrts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // slot table, round-robin search and result register
    rrts_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .kind         (s_tuser[KIND_W-1:0]),
        .target       (s_tdata[TARGET_W-1:0]),
        .status       (status),
        .new_slot     (new_slot),
        .running_slot (running_slot)
    );

    // pack result fields, lowest field first
    assign m_tdata = {2'b00, running_slot, new_slot, status};

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps

// testbench for the round-robin thread slot scheduler
module testbench;
    import rrts_pkg::*;

    localparam int NUM_SLOTS = 16;

    // one scheduler result as it should leave the block
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_FW-1:0]  new_slot;
        logic [SLOT_FW-1:0]  running_slot;
    } sched_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;    // [5:0] target, [7:6] zero
    logic [1:0]  s_tuser  = '0;    // [1:0] kind
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;          // [1:0] status, [7:2] new_slot, [13:8] running_slot

    // own copy of the slot table and the current slot
    logic [SLOT_ST_W-1:0] slot_tbl [NUM_SLOTS];
    int unsigned          cur_slot;

    // results still owed by the block, oldest first
    sched_result_t pending_results[$];
    int            error_count = 0;

    // idle chances in percent, and a long output hold counted by the receiver
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;
    int unsigned hold_cycles  = 0;

    round_robin_thread_slot_scheduler #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // hand the cpu to the next runnable slot after the current one
    function automatic void rotate_to_next();
        int unsigned pick;
        int unsigned probe;
        bit          found;
        found = 1'b0;
        pick  = 0;
        if (slot_tbl[cur_slot] == SL_RUNNING)
            slot_tbl[cur_slot] = SL_RUNNABLE;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            probe = (cur_slot + 1 + k) % NUM_SLOTS;
            if (!found && slot_tbl[probe] == SL_RUNNABLE)
            begin
                found = 1'b1;
                pick  = probe;
            end
        end
        if (!found)
        begin
            // nobody else to run: a runnable current slot resumes, a finished one stays
            if (slot_tbl[cur_slot] == SL_RUNNABLE)
                slot_tbl[cur_slot] = SL_RUNNING;
        end
        else
        begin
            slot_tbl[pick] = SL_RUNNING;
            cur_slot       = pick;
        end
    endfunction

    // apply one request to the table and return the result it causes
    function automatic sched_result_t schedule_request(logic [1:0] kind, logic [5:0] target);
        sched_result_t r;
        bit            claimed;
        r       = '0;
        claimed = 1'b0;
        case (kind)
            K_CREATE:
            begin
                r.status = S_FULL;
                for (int i = 1; i < NUM_SLOTS; i++)
                begin
                    if (!claimed && slot_tbl[i] == SL_FREE)
                    begin
                        claimed     = 1'b1;
                        slot_tbl[i] = SL_RUNNABLE;
                        r.new_slot  = SLOT_FW'(i);
                        r.status    = S_OK;
                    end
                end
            end
            K_YIELD:
                rotate_to_next();
            K_EXIT:
            begin
                slot_tbl[cur_slot] = SL_FINISHED;
                rotate_to_next();
            end
            K_JOIN:
            begin
                if (target == 0 || target >= NUM_SLOTS)
                    r.status = S_BAD_TGT;
                else if (slot_tbl[target] == SL_FINISHED)
                    slot_tbl[target] = SL_FREE;
                else
                begin
                    rotate_to_next();
                    r.status = S_WAITING;
                end
            end
        endcase
        r.running_slot = SLOT_FW'(cur_slot);
        return r;
    endfunction

    // offer one request, possibly after a random gap, and wait for it to be taken
    task automatic send_request(input logic [1:0] kind, input logic [5:0] target);
        if ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, target};
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(schedule_request(kind, target));
    endtask

    // compare one taken result with the oldest one owed
    task automatic check_result();
        sched_result_t got;
        sched_result_t want;
        got.status       = m_tdata[1:0];
        got.new_slot     = m_tdata[7:2];
        got.running_slot = m_tdata[13:8];
        if (pending_results.size() == 0)
        begin
            $error("result with no request outstanding: %h", m_tdata);
            error_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                error_count++;
            end
            if (got.new_slot !== want.new_slot)
            begin
                $error("new_slot: expected %0d, got %0d", want.new_slot, got.new_slot);
                error_count++;
            end
            if (got.running_slot !== want.running_slot)
            begin
                $error("running_slot: expected %0d, got %0d",
                       want.running_slot, got.running_slot);
                error_count++;
            end
        end
    endtask

    // receiving side: check what is taken, then choose the next ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                m_tready    <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // hand-picked requests for the corner cases of the table
    task automatic test_edge_cases();
        send_request(K_YIELD, 6'd0);    // nothing runnable, slot 0 keeps running
        send_request(K_JOIN, 6'd0);     // slot 0 is never a valid target
        send_request(K_JOIN, 6'd63);    // far out of range
        send_request(K_JOIN, 6'd16);    // just past the table
        send_request(K_JOIN, 6'd5);     // free slot: one yield, waiting
        send_request(K_CREATE, 6'd63);  // claims slot 1, target ignored
        send_request(K_JOIN, 6'd1);     // runnable slot: switch to it, waiting
        send_request(K_YIELD, 6'd42);   // back to slot 0
        send_request(K_EXIT, 6'd21);    // slot 0 finishes, slot 1 takes over
        send_request(K_YIELD, 6'd0);    // only the current slot is runnable: picks itself
        send_request(K_CREATE, 6'd0);   // slot 2
        send_request(K_EXIT, 6'd0);     // slot 1 finishes, slot 2 runs
        send_request(K_JOIN, 6'd1);     // finished slot is freed
        send_request(K_JOIN, 6'd2);     // joining oneself: waiting, stays on slot 2
        send_request(K_EXIT, 6'd0);     // nothing left: finished slot stays current
        send_request(K_YIELD, 6'd0);    // still nothing runnable
        // fill the table, the last create finds it full
        for (int i = 0; i < NUM_SLOTS - 1; i++)
            send_request(K_CREATE, 6'(i * 4 + 3));
        send_request(K_JOIN, 6'd2);
    endtask

    // mostly sensible thread traffic, with joins aimed at finished slots
    task automatic test_random_traffic(input int count);
        int unsigned    roll;
        logic [1:0]     kind;
        logic [5:0]     target;
        int unsigned    finished_slots[$];
        for (int n = 0; n < count; n++)
        begin
            roll   = $urandom_range(99);
            target = 6'($urandom_range(63));
            if (roll < 30)
                kind = K_CREATE;
            else if (roll < 55)
                kind = K_YIELD;
            else if (roll < 70)
                kind = K_EXIT;
            else
            begin
                kind = K_JOIN;
                finished_slots.delete();
                for (int i = 1; i < NUM_SLOTS; i++)
                    if (slot_tbl[i] == SL_FINISHED)
                        finished_slots.push_back(i);
                roll = $urandom_range(99);
                if (roll < 45 && finished_slots.size() > 0)
                    target = 6'(finished_slots[$urandom_range(finished_slots.size() - 1)]);
                else if (roll < 85)
                    target = 6'($urandom_range(NUM_SLOTS - 1, 1));
            end
            send_request(kind, target);
        end
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_output_stall();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_cycles  = 300;
        test_random_traffic(40);
    endtask

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
            slot_tbl[i] = SL_FREE;
        slot_tbl[0] = SL_RUNNING;
        cur_slot    = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_cases();

        send_gap_pct = 15;
        recv_gap_pct = 46;
        test_random_traffic(640);

        send_gap_pct = 46;
        recv_gap_pct = 15;
        test_random_traffic(640);

        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_random_traffic(560);

        test_output_stall();

        s_tvalid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #1000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/rrts_pkg.sv
sv/rrts_ctrl.sv
sv/rrts_dp.sv
sv/round_robin_thread_slot_scheduler.sv
sim/testbench.sv
